@@ sv/hash_table_linear_probe_builder_defines.svh @@
// Assertion macros for the linear probe table builder.
`ifndef HASH_TABLE_LINEAR_PROBE_BUILDER_DEFINES_SVH
`define HASH_TABLE_LINEAR_PROBE_BUILDER_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define HTLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define HTLP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HTLP_ASSERT(lbl, prop, msg)
`define HTLP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ sv/htlp_pkg.sv @@
`timescale 1ns / 1ps

package htlp_pkg;

  // Input item function codes
  localparam logic [1:0] FN_CLEAR  = 2'd0;
  localparam logic [1:0] FN_INSERT = 2'd1;
  localparam logic [1:0] FN_READ   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [31:0] hash;
    logic [30:0] key_length;
    logic [63:0] position;
  } entry_t;

  typedef struct packed {
    logic valid_we;
    logic valid_bit;
    logic data_we;
  } mem_wr_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_READ_CHK,
    S_RESP
  } state_t;

endpackage

@@ sv/htlp_div.sv @@
`timescale 1ns / 1ps

module htlp_div #(
  parameter int DW = 24,
  parameter int LW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [LW-1:0] divisor,
  output logic          done,
  output logic [LW-1:0] remainder
);

  localparam int CNTW = $clog2(DW);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   quo;
  logic [LW-1:0]   dvs;
  logic [LW:0]     trial;
  logic [LW:0]     diff;

  // Restoring step: one dividend bit per cycle, quotient discarded
  assign trial = {remainder, quo[DW-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNTW'(DW - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNTW'(DW - 1)) begin
          busy <= 1'b0;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo       <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      quo <= quo << 1;
      if (trial >= {1'b0, dvs}) begin
        remainder <= diff[LW-1:0];
      end else begin
        remainder <= trial[LW-1:0];
      end
    end
  end

endmodule

@@ sv/htlp_mem.sv @@
`timescale 1ns / 1ps

module htlp_mem #(
  parameter int DEPTH = 1024,
  parameter int IW    = 10
) (
  input  logic                    clk,
  input  logic [IW-1:0]           rd_addr,
  output logic                    rd_valid,
  output htlp_pkg::entry_t        rd_data,
  input  logic [IW-1:0]           wr_addr,
  input  htlp_pkg::mem_wr_t       wr,
  input  htlp_pkg::entry_t        wr_data
);

  import htlp_pkg::*;

  logic   vmem [DEPTH];
  entry_t dmem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.valid_we) begin
      vmem[wr_addr] <= wr.valid_bit;
    end
    rd_valid <= vmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.data_we) begin
      dmem[wr_addr] <= wr_data;
    end
    rd_data <= dmem[rd_addr];
  end

endmodule

@@ sv/hash_table_linear_probe_builder.sv @@
`timescale 1ns / 1ps
`include "hash_table_linear_probe_builder_defines.svh"

// Linear probe table builder for one slot of a constant database.
// Input channel (in_valid/in_ready) carries func, key_hash, key_length,
// data_position and read_index; every item yields exactly one result on the
// output channel (out_valid/out_ready): status, slot_index and entry data.
// cfg_wr_en/cfg_wr_data write table_length; write it only while idle.
// Items are taken one at a time; in_ready is high only in the idle state.
// Steps from the accepting edge to the result:
// Insert: the remainder unit reduces the hash, then each probed entry is read
//   and checked on the table memory port, then the result is issued.
// Read: one check of the addressed entry. Clear: a pass over all TABLE_DEPTH entries, one valid bit per cycle.
// Unused func code: the result is issued directly.
// in_ready returns in the cycle the result appears, so a new item is
// accepted only once the result of the last one has been issued.
// Reset runs a clearing pass over all TABLE_DEPTH entries of the valid memory;
// in_ready stays low until it ends. table_length resets to 1024.
// The result goes to an output register; the next item is accepted while it
// waits. If the receiver stalls, the following result holds in the block
// until the register frees, and no further item is taken.
module hash_table_linear_probe_builder #(
  parameter int TABLE_DEPTH = 1024,
  parameter int SLOT_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] key_hash,
  input  logic [30:0] key_length,
  input  logic [63:0] data_position,
  input  logic [9:0]  read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [9:0]  slot_index,
  output logic [31:0] out_hash,
  output logic [30:0] out_key_length,
  output logic [63:0] out_position
);

  import htlp_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int LW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = LW + 1;
  localparam int DW = 32 - SLOT_BITS;

  state_t      state, state_next;
  logic [10:0] table_length;
  logic [LW-1:0] eff;

  logic [IW-1:0] clr_cnt;
  logic          clr_reply;
  logic [IW-1:0] u;
  logic [LW-1:0] tries;
  entry_t        ins_entry;
  logic [9:0]    ridx;
  logic          rok;

  logic [1:0] res_status;
  logic [9:0] res_slot;
  entry_t     res_entry;

  logic          accept;
  logic          div_start;
  logic          div_done;
  logic [LW-1:0] div_rem;
  logic [IW-1:0] rd_addr;
  logic          rd_valid;
  entry_t        rd_data;
  logic [IW-1:0] wr_addr;
  mem_wr_t       wr;
  logic          clr_last;
  logic          probe_last;
  logic          resp_go;
  logic [IW-1:0] u_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= 11'd1024;
    end else if (cfg_wr_en) begin
      table_length <= cfg_wr_data;
    end
  end

  always_comb begin
    if (table_length == '0) begin
      eff = LW'(1);
    end else if (32'(table_length) > 32'(TABLE_DEPTH)) begin
      eff = LW'(TABLE_DEPTH);
    end else begin
      eff = LW'(table_length);
    end
  end

  assign accept     = in_valid && in_ready;
  assign clr_last   = (clr_cnt == IW'(TABLE_DEPTH - 1));
  assign probe_last = ((PW'(tries) + PW'(1)) == PW'(eff));
  assign resp_go    = !out_valid || out_ready;
  // Wrap the probe at the table length
  assign u_inc      = ((PW'(u) + PW'(1)) == PW'(eff)) ? '0 : u + 1'b1;

  htlp_div #(
    .DW(DW),
    .LW(LW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (key_hash[31:SLOT_BITS]),
    .divisor  (eff),
    .done     (div_done),
    .remainder(div_rem)
  );

  htlp_mem #(
    .DEPTH(TABLE_DEPTH),
    .IW   (IW)
  ) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_valid(rd_valid),
    .rd_data (rd_data),
    .wr_addr (wr_addr),
    .wr      (wr),
    .wr_data (ins_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    rd_addr    = IW'(read_index);
    wr_addr    = u;
    wr         = '0;
    unique case (state)
      S_CLEAR: begin
        wr_addr      = clr_cnt;
        wr.valid_we  = 1'b1;
        wr.valid_bit = 1'b0;
        if (clr_last) begin
          state_next = clr_reply ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          priority case (func)
            FN_CLEAR:  state_next = S_CLEAR;
            FN_INSERT: begin
              div_start  = 1'b1;
              state_next = S_DIV;
            end
            FN_READ:   state_next = S_READ_CHK;
            default:   state_next = S_RESP;
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_PROBE_RD;
        end
      end
      S_PROBE_RD: begin
        rd_addr    = u;
        state_next = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        if (!rd_valid) begin
          wr.valid_we  = 1'b1;
          wr.valid_bit = 1'b1;
          wr.data_we   = 1'b1;
          state_next   = S_RESP;
        end else if (probe_last) begin
          state_next = S_RESP;
        end else begin
          state_next = S_PROBE_RD;
        end
      end
      S_READ_CHK: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (resp_go) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Working registers of the current item
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      clr_reply <= 1'b0;
    end else if (state == S_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end else if (accept && func == FN_CLEAR) begin
      clr_cnt   <= '0;
      clr_reply <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ins_entry <= '{hash: key_hash, key_length: key_length, position: data_position};
      ridx      <= read_index;
      rok       <= 32'(read_index) < 32'(TABLE_DEPTH);
    end
    if (state == S_DIV && div_done) begin
      u     <= IW'(div_rem);
      tries <= '0;
    end else if (state == S_PROBE_CHK) begin
      u     <= u_inc;
      tries <= tries + 1'b1;
    end
  end

  // Pending result
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        res_status <= ST_OK;
        res_slot   <= '0;
        res_entry  <= '0;
      end
      S_PROBE_CHK: begin
        if (!rd_valid) begin
          res_status <= ST_OK;
          res_slot   <= 10'(u);
        end else begin
          res_status <= ST_FULL;
          res_slot   <= '0;
        end
      end
      S_READ_CHK: begin
        res_slot <= ridx;
        if (rok && rd_valid) begin
          res_status <= ST_OK;
          res_entry  <= rd_data;
        end else begin
          res_status <= ST_EMPTY;
          res_entry  <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESP && resp_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && resp_go) begin
      status         <= res_status;
      slot_index     <= res_slot;
      out_hash       <= res_entry.hash;
      out_key_length <= res_entry.key_length;
      out_position   <= res_entry.position;
    end
  end

  `HTLP_ASSERT(a_rem_in_range, div_done |-> (PW'(div_rem) < PW'(eff)), "remainder past length")
  `HTLP_ASSERT(a_probe_bound, state == S_PROBE_CHK |-> PW'(tries) < PW'(eff), "probe overran")
  `HTLP_ASSERT(a_accept_leaves_idle, accept |=> (state != S_IDLE), "item left block idle")
  `HTLP_ASSERT_ALWAYS(a_reset_clears, rst |=> state == S_CLEAR && !out_valid, "no clear pass")

endmodule
